[rtl/core/mpr_pkg.sv]
package mpr_pkg;

    // action codes
    localparam logic [2:0] ACT_PIXEL  = 3'd0;
    localparam logic [2:0] ACT_FILL   = 3'd1;
    localparam logic [2:0] ACT_HOLLOW = 3'd2;
    localparam logic [2:0] ACT_LINE   = 3'd3;
    localparam logic [2:0] ACT_READ   = 3'd4;

    // store layout: one page row is always 128 columns apart
    localparam int COL_W = 7;
    localparam int BIT_SEL_MASK = 32'h07;

    // hollow rectangle edges, in walk order
    localparam logic [1:0] EDGE_TOP    = 2'd0;
    localparam logic [1:0] EDGE_BOTTOM = 2'd1;
    localparam logic [1:0] EDGE_LEFT   = 2'd2;
    localparam logic [1:0] EDGE_RIGHT  = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic clear_step;
        logic load;
        logic rect_inc;
        logic setup;
        logic mem_rd;
        logic mem_wr;
        logic read_issue;
        logic read_capture;
        logic rsp_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic is_read;
        logic is_draw;
        logic box_empty;
        logic last_rect;
        logic walk_last;
        logic rsp_free;
    } status_t;

endpackage

[rtl/core/mpr_ram.sv]
module mpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                        wdata,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/mpr_ctrl.sv]
module mpr_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  mpr_pkg::status_t status,
    output mpr_pkg::cmd_t    cmd
);

    import mpr_pkg::*;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_DECODE = 3'd2;
    localparam logic [2:0] S_SETUP  = 3'd3;
    localparam logic [2:0] S_MRD    = 3'd4;
    localparam logic [2:0] S_MWR    = 3'd5;
    localparam logic [2:0] S_RWAIT  = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (status.is_read)
                begin
                    cmd.read_issue = 1'b1;
                    state_next     = S_RWAIT;
                end
                else if (status.is_draw)
                begin
                    state_next = S_SETUP;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SETUP:
            begin
                cmd.setup = 1'b1;
                if (!status.box_empty)
                begin
                    state_next = S_MRD;
                end
                else if (status.last_rect)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.rect_inc = 1'b1;
                end
            end
            S_MRD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_MWR;
            end
            S_MWR:
            begin
                cmd.mem_wr = 1'b1;
                if (!status.walk_last)
                begin
                    state_next = S_MRD;
                end
                else if (status.last_rect)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.rect_inc = 1'b1;
                    state_next   = S_SETUP;
                end
            end
            S_RWAIT:
            begin
                cmd.read_capture = 1'b1;
                state_next       = S_DONE;
            end
            S_DONE:
            begin
                if (status.rsp_free)
                begin
                    cmd.rsp_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // a result is only loaded into a free output slot
    a_rsp_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rsp_load |-> status.rsp_free)
        else $error("result loaded over a pending result");

    // an accepted request is decoded in the next cycle
    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg == S_DECODE))
        else $error("accepted request not decoded");

    // no request is taken before the clearing pass ends
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR && !status.clear_last) |=> !req_ready)
        else $error("request port opened during clear");

endmodule

[rtl/core/mpr_datapath.sv]
module mpr_datapath #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  mpr_pkg::cmd_t      cmd,
    output mpr_pkg::status_t   status,
    input  logic [2:0]         action,
    input  logic signed [7:0]  x_pos,
    input  logic signed [7:0]  y_pos,
    input  logic [7:0]         span_width,
    input  logic [7:0]         span_height,
    input  logic               pixel_on,
    input  logic [2:0]         read_page,
    input  logic [6:0]         read_column,
    input  logic               rsp_ready,
    output logic               rsp_valid,
    output logic [7:0]         read_data,
    output logic               drew_any
);

    import mpr_pkg::*;

    localparam int PAGE_COUNT  = (SCREEN_HEIGHT + 7) / 8;
    localparam int PAGE_W      = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int ADDR_W      = PAGE_W + COL_W;
    localparam int RAM_DEPTH   = 1 << ADDR_W;
    localparam int STORE_BYTES = PAGE_COUNT * (1 << COL_W);
    localparam logic signed [9:0] X_MAX = 10'(SCREEN_WIDTH - 1);
    localparam logic signed [9:0] Y_MAX = 10'(SCREEN_HEIGHT - 1);

    // latched request
    logic [2:0]        act_reg;
    logic signed [7:0] x_reg;
    logic signed [7:0] y_reg;
    logic [7:0]        w_reg;
    logic [7:0]        h_reg;
    logic              on_reg;
    logic [2:0]        rpage_reg;
    logic [6:0]        rcol_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg   <= action;
            x_reg     <= x_pos;
            y_reg     <= y_pos;
            w_reg     <= span_width;
            h_reg     <= span_height;
            on_reg    <= pixel_on;
            rpage_reg <= read_page;
            rcol_reg  <= read_column;
        end
    end

    // edge counter for the hollow rectangle
    logic [1:0] rect_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rect_reg <= EDGE_TOP;
        end
        else if (cmd.load)
        begin
            rect_reg <= EDGE_TOP;
        end
        else if (cmd.rect_inc)
        begin
            rect_reg <= rect_reg + 2'd1;
        end
    end

    // box for the current step, edge coordinates wrap to 8 bits
    logic [7:0]        y_bottom;
    logic [7:0]        x_right;
    logic signed [7:0] bx;
    logic signed [7:0] by;
    logic [7:0]        bw;
    logic [7:0]        bh;

    assign y_bottom = 8'(y_reg + h_reg - 8'd1);
    assign x_right  = 8'(x_reg + w_reg - 8'd1);

    always_comb
    begin
        bx = x_reg;
        by = y_reg;
        bw = w_reg;
        bh = h_reg;
        case (act_reg)
            ACT_PIXEL:
            begin
                bw = 8'd1;
                bh = 8'd1;
            end
            ACT_LINE:
            begin
                bh = 8'd1;
            end
            ACT_HOLLOW:
            begin
                case (rect_reg)
                    EDGE_TOP:
                    begin
                        bh = 8'd1;
                    end
                    EDGE_BOTTOM:
                    begin
                        by = y_bottom;
                        bh = 8'd1;
                    end
                    EDGE_LEFT:
                    begin
                        bw = 8'd1;
                    end
                    EDGE_RIGHT:
                    begin
                        bx = x_right;
                        bw = 8'd1;
                    end
                    default:
                    begin
                        bh = 8'd1;
                    end
                endcase
            end
            default:
            begin
                bx = x_reg;
            end
        endcase
    end

    // clip the box to the screen
    logic signed [9:0] x_lo;
    logic signed [9:0] x_end;
    logic signed [9:0] x_hi;
    logic signed [9:0] y_lo;
    logic signed [9:0] y_end;
    logic signed [9:0] y_hi;
    logic              box_empty;

    always_comb
    begin
        x_end     = 10'(bx) + $signed({2'b00, bw}) - 10'sd1;
        y_end     = 10'(by) + $signed({2'b00, bh}) - 10'sd1;
        x_lo      = bx[7] ? 10'sd0 : 10'(bx);
        y_lo      = by[7] ? 10'sd0 : 10'(by);
        x_hi      = (x_end > X_MAX) ? X_MAX : x_end;
        y_hi      = (y_end > Y_MAX) ? Y_MAX : y_end;
        box_empty = (x_lo > x_hi) || (y_lo > y_hi);
    end

    // walker over the clipped box, page by page, column by column
    logic [6:0]        col_lo_reg;
    logic [6:0]        col_hi_reg;
    logic [6:0]        row_lo_reg;
    logic [6:0]        row_hi_reg;
    logic [6:0]        col_reg;
    logic [PAGE_W-1:0] page_reg;
    logic              walk_last;
    logic              col_last;
    logic              page_last;

    assign col_last  = (col_reg == col_hi_reg);
    assign page_last = (4'(page_reg) == row_hi_reg[6:3]);
    assign walk_last = col_last && page_last;

    always_ff @(posedge clk)
    begin
        if (cmd.setup)
        begin
            col_lo_reg <= x_lo[6:0];
            col_hi_reg <= x_hi[6:0];
            row_lo_reg <= y_lo[6:0];
            row_hi_reg <= y_hi[6:0];
            col_reg    <= x_lo[6:0];
            page_reg   <= PAGE_W'(y_lo[6:3]);
        end
        else if (cmd.mem_wr)
        begin
            if (col_last)
            begin
                col_reg  <= col_lo_reg;
                page_reg <= page_reg + PAGE_W'(1);
            end
            else
            begin
                col_reg <= col_reg + 7'd1;
            end
        end
    end

    // rows of the box that fall in the current page
    logic [2:0] bit_lo;
    logic [2:0] bit_hi;
    logic [7:0] wr_mask;

    always_comb
    begin
        bit_lo  = (4'(page_reg) == row_lo_reg[6:3]) ? row_lo_reg[2:0] : 3'd0;
        bit_hi  = page_last ? row_hi_reg[2:0] : 3'(BIT_SEL_MASK);
        wr_mask = (8'hFF << bit_lo) & (8'hFF >> (3'(BIT_SEL_MASK) - bit_hi));
    end

    // clearing pass counter
    logic [ADDR_W-1:0] clear_addr_reg;
    logic              clear_last;

    assign clear_last = (clear_addr_reg == ADDR_W'(STORE_BYTES - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_addr_reg <= '0;
        end
        else if (cmd.clear_step)
        begin
            clear_addr_reg <= clear_addr_reg + ADDR_W'(1);
        end
    end

    // frame store port
    logic [ADDR_W-1:0] ram_addr;
    logic              ram_we;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;

    always_comb
    begin
        if (cmd.clear_step)
        begin
            ram_addr = clear_addr_reg;
        end
        else if (cmd.read_issue)
        begin
            ram_addr = {PAGE_W'(rpage_reg), rcol_reg};
        end
        else
        begin
            ram_addr = {page_reg, col_reg};
        end
        ram_we = cmd.clear_step || cmd.mem_wr;
        if (cmd.clear_step)
        begin
            ram_wdata = 8'h00;
        end
        else if (on_reg)
        begin
            ram_wdata = ram_rdata | wr_mask;
        end
        else
        begin
            ram_wdata = ram_rdata & ~wr_mask;
        end
    end

    mpr_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // per-request result accumulation
    logic       any_reg;
    logic [7:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            any_reg  <= 1'b0;
            data_reg <= 8'h00;
        end
        else
        begin
            if (cmd.setup && !box_empty)
            begin
                any_reg <= 1'b1;
            end
            if (cmd.read_capture)
            begin
                data_reg <= ram_rdata;
            end
        end
    end

    // output register
    logic       rsp_valid_reg;
    logic [7:0] read_data_reg;
    logic       drew_any_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.rsp_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rsp_load)
        begin
            read_data_reg <= data_reg;
            drew_any_reg  <= any_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign read_data = read_data_reg;
    assign drew_any  = drew_any_reg;

    // status to the controller
    always_comb
    begin
        status.clear_last = clear_last;
        status.is_read    = (act_reg == ACT_READ) && (5'(rpage_reg) < 5'(PAGE_COUNT));
        status.is_draw    = act_reg inside {[ACT_PIXEL:ACT_LINE]};
        status.box_empty  = box_empty;
        status.last_rect  = (act_reg != ACT_HOLLOW) || (rect_reg == EDGE_RIGHT);
        status.walk_last  = walk_last;
        status.rsp_free   = !rsp_valid_reg || rsp_ready;
    end

    // stores never go past the screen's pages
    a_store_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (ram_addr < ADDR_W'(STORE_BYTES - 1) || ram_addr == ADDR_W'(STORE_BYTES - 1)))
        else $error("store write outside the screen pages");

    // a drawing write always touches at least one pixel
    a_mask_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mem_wr |-> (wr_mask != 8'h00))
        else $error("empty pixel mask on draw write");

    // a drawing write follows its read of the same byte
    a_rmw_pair: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mem_wr |-> ($past(cmd.mem_rd) && $stable(ram_addr)))
        else $error("write without matching read");

endmodule

[rtl/core/mono_page_rect_draw.sv]
// channel   signals                                    direction
// request   req_valid req_ready action x_pos y_pos     in
//           span_width span_height pixel_on
//           read_page read_column
// response  rsp_valid rsp_ready read_data drew_any     out
//
// one request at a time; drawing walks the clipped box in store bytes,
// each byte read then written on the single store port, after a setup
// step per box
// after reset the store is cleared, one byte per cycle, all 128 * pages
// bytes (1024 at 128 x 64), with req_ready low
// a finished result waits in the output register; a new request is taken
// meanwhile and only its own result waits for rsp_ready
module mono_page_rect_draw #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  logic [2:0]        action,
    input  logic signed [7:0] x_pos,
    input  logic signed [7:0] y_pos,
    input  logic [7:0]        span_width,
    input  logic [7:0]        span_height,
    input  logic              pixel_on,
    input  logic [2:0]        read_page,
    input  logic [6:0]        read_column,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output logic [7:0]        read_data,
    output logic              drew_any
);

    import mpr_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencer
    mpr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // clipping, byte walker, frame store and result registers
    mpr_datapath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .action      (action),
        .x_pos       (x_pos),
        .y_pos       (y_pos),
        .span_width  (span_width),
        .span_height (span_height),
        .pixel_on    (pixel_on),
        .read_page   (read_page),
        .read_column (read_column),
        .rsp_ready   (rsp_ready),
        .rsp_valid   (rsp_valid),
        .read_data   (read_data),
        .drew_any    (drew_any)
    );

endmodule
